>>> hw/rtl/lnig_pkg.sv
// shared constants, register and lattice codes, and offset tables for the
// lattice neighbor index generator; no dependencies
package lnig_pkg;

    localparam int SITE_W       = 14;
    localparam int DEF_MAX_SIDE = 64;
    localparam int MIN_SIDE     = 3;

    localparam logic [1:0] KIND_CHAIN   = 2'd0;
    localparam logic [1:0] KIND_SQUARE  = 2'd1;
    localparam logic [1:0] KIND_TRI     = 2'd2;
    localparam logic [1:0] KIND_KAGOME  = 2'd3;

    localparam logic REG_LATTICE_KIND = 1'b0;
    localparam logic REG_SIDE_LENGTH  = 1'b1;

    localparam logic [1:0] SHELL_PLAQ = 2'd3;

    typedef struct packed {
        logic signed [2:0] dx;
        logic signed [2:0] dy;
        logic [1:0]        qn;
        logic [1:0]        shell;
        logic [3:0]        slot;
        logic              link;
        logic              last;
    } ent_t;

    localparam int CH_DX [6] = '{1, -1, 2, -2, 3, -3};

    localparam int SQ_DX [11] = '{1, 0, -1, 0, 1, -1, -1, 1, 1, 1, 0};
    localparam int SQ_DY [11] = '{0, 1, 0, -1, 1, 1, -1, -1, 0, 1, 1};

    localparam int TR_DX [27] = '{1, 1, 0, -1, -1, 0, 2, 1, -1, -2, -1, 1,
                                  2, 2, 0, -2, -2, 0, 1, 1, 0, 1, 1, 0, 1, 2, 1};
    localparam int TR_DY [27] = '{0, 1, 1, 0, -1, -1, 1, 2, 1, -1, -2, -1,
                                  0, 2, 2, 0, -2, -2, 0, 1, 1, 1, 2, 1, 0, 1, 1};

    localparam int KG_DX [30] = '{0, 0, 1, 0, 0, 1, -1, 1, -1, 1,
                                  0, 1, 0, 0, -1, 1, 0, 1, -1, 1,
                                  -1, 0, -1, 0, -1, 0, 0, -1, 0, 0};
    localparam int KG_DY [30] = '{0, -1, 0, -1, 0, -1, -1, 0, 0, 0,
                                  0, 0, 1, 0, 0, 1, -1, 1, -1, 1,
                                  0, 1, 0, 0, -1, 1, 0, 1, -1, 1};
    localparam int KG_Q  [30] = '{1, 1, 2, 2, 2, 2, 1, 1, 0, 0,
                                  2, 2, 0, 0, 0, 0, 2, 2, 1, 1,
                                  0, 0, 1, 1, 1, 1, 0, 0, 2, 2};

    // offset, shell, slot and link flag of entry k for a lattice and sublattice
    function automatic ent_t lat_entry(input logic [1:0] kind, input logic [1:0] q,
                                       input logic [4:0] k);
        ent_t e;
        int   ki;
        int   ix;
        e  = '0;
        ki = int'(k);
        ix = 0;
        unique case (kind)
            KIND_CHAIN: begin
                if (ki < 6) begin
                    e.dx    = 3'(CH_DX[ki]);
                    e.shell = 2'(ki / 2);
                    e.slot  = 4'(ki % 2);
                    e.link  = (ki % 2) == 0;
                    e.last  = ki == 5;
                end
            end
            KIND_SQUARE: begin
                if (ki < 11) begin
                    e.dx = 3'(SQ_DX[ki]);
                    e.dy = 3'(SQ_DY[ki]);
                    if (ki < 4) begin
                        e.shell = 2'd0;
                        e.slot  = 4'(ki);
                    end else if (ki < 8) begin
                        e.shell = 2'd1;
                        e.slot  = 4'(ki - 4);
                    end else begin
                        e.shell = SHELL_PLAQ;
                        e.slot  = 4'(ki - 8);
                    end
                    e.link = (ki < 8) && (e.slot < 4'd2);
                    e.last = ki == 10;
                end
            end
            KIND_TRI: begin
                if (ki < 27) begin
                    e.dx = 3'(TR_DX[ki]);
                    e.dy = 3'(TR_DY[ki]);
                    if (ki < 6) begin
                        e.shell = 2'd0;
                        e.slot  = 4'(ki);
                    end else if (ki < 12) begin
                        e.shell = 2'd1;
                        e.slot  = 4'(ki - 6);
                    end else if (ki < 18) begin
                        e.shell = 2'd2;
                        e.slot  = 4'(ki - 12);
                    end else begin
                        e.shell = SHELL_PLAQ;
                        e.slot  = 4'(ki - 18);
                    end
                    e.link = (ki < 18) && (e.slot < 4'd3);
                    e.last = ki == 26;
                end
            end
            KIND_KAGOME: begin
                if (ki < 10 && q < 2'd3) begin
                    ix   = int'(q) * 10 + ki;
                    e.dx = 3'(KG_DX[ix]);
                    e.dy = 3'(KG_DY[ix]);
                    e.qn = 2'(KG_Q[ix]);
                    if (ki < 4) begin
                        e.shell = 2'd0;
                        e.slot  = 4'(ki);
                        e.link  = ki < 2;
                    end else if (ki < 8) begin
                        e.shell = 2'd1;
                        e.slot  = 4'(ki - 4);
                        e.link  = ki < 6;
                    end else begin
                        e.shell = 2'd2;
                        e.slot  = 4'(ki - 8);
                        e.link  = ki == 8;
                    end
                    e.last = ki == 9;
                end
            end
        endcase
        return e;
    endfunction

endpackage

>>> hw/rtl/lnig_front.sv
// front end: accepts a site index, range-checks it and splits it into cell
// coordinates and sublattice; uses lnig_pkg
module lnig_front #(
    parameter int MAX_SIDE = lnig_pkg::DEF_MAX_SIDE,
    parameter int IW       = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lnig_pkg::SITE_W-1:0]   s_site_index,
    input  logic [1:0]                    lattice_kind,
    input  logic [6:0]                    side_length,
    output logic                          push_valid,
    output logic [IW-1:0]                 push_data,
    input  logic                          queue_full
);

    localparam int LW   = $clog2(MAX_SIDE + 1);
    localparam int CW   = $clog2(MAX_SIDE);
    localparam int BW   = $clog2(CW);
    localparam int CNTW = 2 * LW + 2;
    localparam int SW   = lnig_pkg::SITE_W;

    typedef enum logic [1:0] {F_IDLE, F_CHK, F_DIV, F_PUSH} fstate_t;

    fstate_t           state_reg, state_next;
    logic [SW-1:0]     site_reg, site_next;
    logic [1:0]        kind_reg, kind_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [SW-1:0]     cell_reg, cell_next;
    logic [2*LW-1:0]   sq_reg, sq_next;
    logic [SW-1:0]     rem_reg, rem_next;
    logic [CW-1:0]     quo_reg, quo_next;
    logic [BW-1:0]     bit_reg, bit_next;
    logic [1:0]        q_reg, q_next;
    logic              bad_reg, bad_next;

    logic [LW-1:0]     len_c;
    logic [29:0]       prod_c;
    logic [CNTW-1:0]   count_c;
    logic [SW-1:0]     three_cell_c;
    logic [31:0]       trial_c;

    always_comb begin
        if (side_length < 7'(lnig_pkg::MIN_SIDE)) begin
            len_c = LW'(lnig_pkg::MIN_SIDE);
        end else if (32'(side_length) > 32'(MAX_SIDE)) begin
            len_c = LW'(MAX_SIDE);
        end else begin
            len_c = LW'(side_length);
        end
    end

    // divide by three through the reciprocal 43691 / 2^17
    assign prod_c       = 30'(s_site_index) * 30'(43691);
    assign three_cell_c = SW'({cell_reg, 1'b0}) + cell_reg;
    assign trial_c      = 32'(len_reg) << bit_reg;

    always_comb begin
        unique case (kind_reg)
            lnig_pkg::KIND_CHAIN:  count_c = CNTW'(len_reg);
            lnig_pkg::KIND_KAGOME: count_c = CNTW'(sq_reg) + CNTW'({sq_reg, 1'b0});
            default:               count_c = CNTW'(sq_reg);
        endcase
    end

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = {kind_reg, len_reg, rem_reg[CW-1:0], quo_reg, q_reg, bad_reg};

    always_comb begin
        state_next = state_reg;
        site_next  = site_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        cell_next  = cell_reg;
        sq_next    = sq_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        bit_next   = bit_reg;
        q_next     = q_reg;
        bad_next   = bad_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    site_next  = s_site_index;
                    kind_next  = lattice_kind;
                    len_next   = len_c;
                    cell_next  = SW'(prod_c >> 17);
                    sq_next    = (2*LW)'(len_c) * (2*LW)'(len_c);
                    state_next = F_CHK;
                end
            end
            F_CHK: begin
                bad_next = 32'(site_reg) >= 32'(count_c);
                quo_next = '0;
                bit_next = BW'(CW - 1);
                if (kind_reg == lnig_pkg::KIND_KAGOME) begin
                    q_next   = 2'(site_reg - three_cell_c);
                    rem_next = cell_reg;
                end else begin
                    q_next   = 2'd0;
                    rem_next = site_reg;
                end
                state_next = (32'(site_reg) >= 32'(count_c)) ? F_PUSH : F_DIV;
            end
            F_DIV: begin
                // restoring division by the side length, one quotient bit a cycle
                if (32'(rem_reg) >= trial_c) begin
                    rem_next          = rem_reg - SW'(trial_c);
                    quo_next[bit_reg] = 1'b1;
                end
                if (bit_reg == '0) begin
                    state_next = F_PUSH;
                end else begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            F_PUSH: begin
                if (!queue_full) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        site_reg <= site_next;
        kind_reg <= kind_next;
        len_reg  <= len_next;
        cell_reg <= cell_next;
        sq_reg   <= sq_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        bit_reg  <= bit_next;
        q_reg    <= q_next;
        bad_reg  <= bad_next;
    end

endmodule

>>> hw/rtl/lnig_queue.sv
// two-entry queue between front end and back end of the neighbor generator;
// no package dependencies
module lnig_queue #(
    parameter int IW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    input  logic [IW-1:0] push_data,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output logic [IW-1:0] head_data
);

    logic [IW-1:0] mem_reg [2];
    logic          wr_reg, wr_next;
    logic          rd_reg, rd_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_data  = mem_reg[rd_reg];
    assign do_push    = push_valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_next  = do_push ? ~wr_reg : wr_reg;
        rd_next  = do_pop ? ~rd_reg : rd_reg;
        cnt_next = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule

>>> hw/rtl/lnig_back.sv
// back end: walks the offset table for the queued site, wraps coordinates and
// forms the linear neighbor index over two stages; uses lnig_pkg
module lnig_back #(
    parameter int MAX_SIDE = lnig_pkg::DEF_MAX_SIDE,
    parameter int IW       = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  logic [IW-1:0]                 head_data,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_shell,
    output logic [3:0]                    m_slot,
    output logic [lnig_pkg::SITE_W-1:0]   m_neighbor_site,
    output logic                          m_is_link,
    output logic                          m_bad_site,
    output logic                          m_last
);

    localparam int LW = $clog2(MAX_SIDE + 1);
    localparam int CW = $clog2(MAX_SIDE);
    localparam int XW = LW + 2;
    localparam int PW = CW + LW + 3;

    logic [1:0]      h_kind;
    logic [LW-1:0]   h_len;
    logic [CW-1:0]   h_x;
    logic [CW-1:0]   h_y;
    logic [1:0]      h_q;
    logic            h_bad;
    lnig_pkg::ent_t  ent;
    logic            gen_last;
    logic            gen_fire;
    logic            a_adv;

    logic [4:0]      k_reg, k_next;
    logic            a_valid_reg, a_valid_next;
    logic [CW-1:0]   a_nx_reg, a_ny_reg;
    logic [LW-1:0]   a_len_reg;
    logic            a_kag_reg;
    logic [1:0]      a_qn_reg, a_shell_reg;
    logic [3:0]      a_slot_reg;
    logic            a_link_reg, a_bad_reg, a_last_reg;

    logic            m_valid_reg, m_valid_next;
    logic [1:0]      m_shell_reg;
    logic [3:0]      m_slot_reg;
    logic [lnig_pkg::SITE_W-1:0] m_site_reg;
    logic            m_link_reg, m_bad_reg, m_last_reg;

    logic [PW-1:0]   lin_c;
    logic [PW-1:0]   site_c;

    // coordinate plus a small offset, folded back onto the torus
    function automatic logic [CW-1:0] wrap_c(input logic [CW-1:0] c,
                                             input logic signed [2:0] d,
                                             input logic [LW-1:0] l);
        logic signed [XW-1:0] v;
        logic signed [XW-1:0] ls;
        ls = $signed(XW'(l));
        v  = $signed(XW'(c)) + XW'(d);
        if (v < 0) begin
            v = v + ls;
        end else if (v >= ls) begin
            v = v - ls;
        end
        return CW'(v);
    endfunction

    assign {h_kind, h_len, h_x, h_y, h_q, h_bad} = head_data;

    assign ent      = lnig_pkg::lat_entry(h_kind, h_q, k_reg);
    assign gen_last = h_bad || ent.last;
    assign a_adv    = !m_valid_reg || m_ready;
    assign gen_fire = head_valid && (!a_valid_reg || a_adv);
    assign pop      = gen_fire && gen_last;

    always_comb begin
        k_next       = k_reg;
        a_valid_next = a_valid_reg;
        if (gen_fire) begin
            a_valid_next = 1'b1;
            k_next       = gen_last ? 5'd0 : k_reg + 5'd1;
        end else if (a_adv) begin
            a_valid_next = 1'b0;
        end
    end

    assign lin_c  = PW'(a_ny_reg) * PW'(a_len_reg) + PW'(a_nx_reg);
    assign site_c = (a_kag_reg ? (lin_c << 1) + lin_c : lin_c) + PW'(a_qn_reg);

    assign m_valid_next = a_adv ? a_valid_reg : m_valid_reg;

    assign m_valid         = m_valid_reg;
    assign m_shell         = m_shell_reg;
    assign m_slot          = m_slot_reg;
    assign m_neighbor_site = m_site_reg;
    assign m_is_link       = m_link_reg;
    assign m_bad_site      = m_bad_reg;
    assign m_last          = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= 5'd0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            k_reg       <= k_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
        if (gen_fire) begin
            a_nx_reg    <= wrap_c(h_x, ent.dx, h_len);
            a_ny_reg    <= wrap_c(h_y, ent.dy, h_len);
            a_len_reg   <= h_len;
            a_kag_reg   <= (h_kind == lnig_pkg::KIND_KAGOME);
            a_qn_reg    <= ent.qn;
            a_shell_reg <= h_bad ? 2'd0 : ent.shell;
            a_slot_reg  <= h_bad ? 4'd0 : ent.slot;
            a_link_reg  <= !h_bad && ent.link;
            a_bad_reg   <= h_bad;
            a_last_reg  <= gen_last;
        end
        if (a_adv && a_valid_reg) begin
            m_shell_reg <= a_shell_reg;
            m_slot_reg  <= a_slot_reg;
            m_site_reg  <= a_bad_reg ? '0 : lnig_pkg::SITE_W'(site_c);
            m_link_reg  <= a_link_reg;
            m_bad_reg   <= a_bad_reg;
            m_last_reg  <= a_last_reg;
        end
    end

endmodule

>>> hw/rtl/lattice_neighbor_index_generator.sv
// top level of the periodic lattice neighbor index generator: configuration
// registers, front end, queue and back end; uses lnig_pkg
//
// For each accepted site index the block streams that site's neighbor
// indices on a periodic chain, square, triangular or kagome lattice, one
// result per cycle while m_ready is high: 6, 11, 27 or 10 results, or one
// error result when the site is out of range. The front end takes one site
// at a time and splits it with a bit-serial divider by the side length,
// which a site out of range skips; the back end then emits one result a
// cycle, while m_ready allows, through a two-stage pipeline. A two-entry
// queue lets the front end split the next sites while the back end is still
// emitting. Configuration (lattice_kind at index 0, side_length at index 1)
// must be written only while no site is in flight.
module lattice_neighbor_index_generator #(
    parameter int MAX_SIDE = lnig_pkg::DEF_MAX_SIDE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [6:0]                    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lnig_pkg::SITE_W-1:0]   s_site_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_shell,
    output logic [3:0]                    m_slot,
    output logic [lnig_pkg::SITE_W-1:0]   m_neighbor_site,
    output logic                          m_is_link,
    output logic                          m_bad_site,
    output logic                          m_last
);

    localparam int LW = $clog2(MAX_SIDE + 1);
    localparam int CW = $clog2(MAX_SIDE);
    localparam int IW = 2 + LW + 2 * CW + 2 + 1;

    logic [1:0]    kind_reg, kind_next;
    logic [6:0]    side_reg, side_next;
    logic          push_valid;
    logic [IW-1:0] push_data;
    logic          queue_full;
    logic          pop;
    logic          head_valid;
    logic [IW-1:0] head_data;

    assign cfg_ready = 1'b1;

    always_comb begin
        kind_next = kind_reg;
        side_next = side_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                lnig_pkg::REG_LATTICE_KIND: kind_next = cfg_data[1:0];
                lnig_pkg::REG_SIDE_LENGTH:  side_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= lnig_pkg::KIND_SQUARE;
            side_reg <= 7'd4;
        end else begin
            kind_reg <= kind_next;
            side_reg <= side_next;
        end
    end

    lnig_front #(
        .MAX_SIDE (MAX_SIDE),
        .IW       (IW)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_site_index (s_site_index),
        .lattice_kind (kind_reg),
        .side_length  (side_reg),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .queue_full   (queue_full)
    );

    lnig_queue #(
        .IW (IW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    lnig_back #(
        .MAX_SIDE (MAX_SIDE),
        .IW       (IW)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head_valid      (head_valid),
        .head_data       (head_data),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_shell         (m_shell),
        .m_slot          (m_slot),
        .m_neighbor_site (m_neighbor_site),
        .m_is_link       (m_is_link),
        .m_bad_site      (m_bad_site),
        .m_last          (m_last)
    );

endmodule
